/* design/sra_pkg.sv */
// Shared constants, payload types and status codes for the station record aggregator.
`default_nettype none
package sra_pkg;

    localparam int STATIONS    = 1024;
    localparam int NAME_BYTES  = 128;

    localparam int SLOT_W      = $clog2(STATIONS);
    localparam int USED_W      = $clog2(STATIONS + 1);
    localparam int LEN_W       = $clog2(NAME_BYTES + 1);
    localparam int NB_IDX_W    = $clog2(NAME_BYTES);
    localparam int NAME_ADDR_W = $clog2(STATIONS * NAME_BYTES);

    localparam int STATUS_W    = 3;
    localparam int OUT_SLOT_W  = 10;
    localparam int COUNT_W     = 32;
    localparam int TOTAL_W     = 48;
    localparam int VALUE_W     = 16;
    localparam int MAG_W       = TOTAL_W + 1;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUERY_OK = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [VALUE_W-1:0] RADIX = 16'd10;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            data_byte;
        logic [OUT_SLOT_W-1:0] query_slot;
    } sra_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [OUT_SLOT_W-1:0]     slot;
        logic [COUNT_W-1:0]        count;
        logic signed [TOTAL_W-1:0] total;
        logic signed [VALUE_W-1:0] minimum;
        logic signed [VALUE_W-1:0] maximum;
        logic signed [VALUE_W-1:0] mean_tenths;
    } sra_out_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        logic signed [TOTAL_W-1:0] total;
        logic signed [VALUE_W-1:0] minimum;
        logic signed [VALUE_W-1:0] maximum;
    } sra_fig_t;

endpackage
`default_nettype wire

/* design/sra_div.sv */
// Restoring divider, one quotient bit per cycle, for the rounded mean.
`default_nettype none
module sra_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [sra_pkg::MAG_W-1:0]   dividend,
    input  wire logic [sra_pkg::COUNT_W-1:0] divisor,
    output logic                             done,
    output logic [sra_pkg::MAG_W-1:0]        quotient
);
    import sra_pkg::*;

    localparam int STEP_W = $clog2(MAG_W);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [MAG_W-1:0]   dq_reg;
    logic [COUNT_W:0]   rem_reg;
    logic [COUNT_W-1:0] dvs_reg;

    logic [COUNT_W:0]   rem_sh;
    logic               ge;
    logic [COUNT_W:0]   rem_new;

    assign rem_sh  = {rem_reg[COUNT_W-1:0], dq_reg[MAG_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_new = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(MAG_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[MAG_W-2:0], ge};
            rem_reg <= rem_new;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

/* design/station_record_aggregator.sv */
// Station record aggregator: parses name;value lines and keeps per-station statistics.
//
// Input channel s_*: one word per stream byte (kind 0) or per table query (kind 1).
// Output channel m_*: one status word per finished line (newline in the value
// field) and one per query; other bytes produce nothing.
// A plain byte only updates the parser state. At a line end a sequencer walks the
// stored names: it reads each stored slot's length and, on a length match,
// compares the name byte by byte, reading and then checking each byte. A new name
// is copied byte by byte, each byte read and then written. The rounded mean then
// goes through a shared bit-serial divider; a query on a used slot reads the
// figures and divides, and a query on an unused slot answers without the divider.
// The block takes no word while it works on a line end or a query.
// Reset (aresetn low, synchronous) empties the table and restarts line parsing;
// no clearing pass runs since every slot is written before it is first read.
// The result sits in an output register; if the receiver stalls, the next
// result waits in the sequencer until m_ready frees the register, and no
// word is taken meanwhile.
`default_nettype none
module station_record_aggregator (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sra_pkg::sra_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sra_pkg::sra_out_t      m_data
);
    import sra_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LEN_RD    = 4'd1;
    localparam logic [3:0] S_LEN_CHK   = 4'd2;
    localparam logic [3:0] S_BYTE_RD   = 4'd3;
    localparam logic [3:0] S_BYTE_CHK  = 4'd4;
    localparam logic [3:0] S_FIG_RD    = 4'd5;
    localparam logic [3:0] S_FIG_UPD   = 4'd6;
    localparam logic [3:0] S_COPY_RD   = 4'd7;
    localparam logic [3:0] S_COPY_WR   = 4'd8;
    localparam logic [3:0] S_DIV_START = 4'd9;
    localparam logic [3:0] S_DIV_WAIT  = 4'd10;
    localparam logic [3:0] S_EMIT      = 4'd11;

    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

    // storage
    logic [7:0]       name_buf  [NAME_BYTES];
    logic [7:0]       names_mem [STATIONS*NAME_BYTES];
    logic [LEN_W-1:0] len_mem   [STATIONS];
    sra_fig_t         fig_mem   [STATIONS];

    logic [7:0]       buf_rd_reg;
    logic [7:0]       names_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;
    sra_fig_t         fig_rd_reg;

    // control
    logic [3:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [LEN_W-1:0]    name_len_reg, name_len_next;
    logic                too_long_reg, too_long_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic                m_valid_reg, m_valid_next;

    // working registers
    logic [USED_W-1:0]         srch_reg, srch_next;
    logic [LEN_W-1:0]          idx_reg, idx_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [OUT_SLOT_W-1:0]     oslot_reg, oslot_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic                      fig_ok_reg, fig_ok_next;
    logic signed [VALUE_W-1:0] v_reg, v_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [TOTAL_W-1:0] tot_reg, tot_next;
    logic signed [VALUE_W-1:0] min_reg, min_next;
    logic signed [VALUE_W-1:0] max_reg, max_next;
    logic signed [VALUE_W-1:0] mean_reg, mean_next;
    logic                      mneg_reg, mneg_next;
    sra_out_t                  m_data_reg, m_data_next;

    // memory ports
    logic                   buf_we;
    logic [SLOT_W-1:0]      srch_slot;
    logic [NAME_ADDR_W-1:0] name_addr;
    logic                   names_we;
    logic                   len_we;
    logic                   fig_we;
    sra_fig_t               fig_wdata;

    // divider
    logic               div_start;
    logic               div_done;
    logic [MAG_W-1:0]   div_quo;
    logic [MAG_W-1:0]   tot_ext;
    logic [MAG_W-1:0]   tot_mag;
    logic [MAG_W-1:0]   dividend;
    logic               tot_pos;

    // update arithmetic
    logic [MAG_W-1:0]   sum_ext;
    logic               accepted;
    logic [7:0]         b;

    assign accepted  = s_valid && s_ready;
    assign b         = s_data.data_byte;
    assign srch_slot = srch_reg[SLOT_W-1:0];
    assign name_addr = NAME_ADDR_W'(srch_slot) * NAME_ADDR_W'(NAME_BYTES)
                       + NAME_ADDR_W'(idx_reg);

    assign tot_ext  = {tot_reg[TOTAL_W-1], tot_reg};
    assign tot_mag  = tot_reg[TOTAL_W-1] ? (~tot_ext + 1'b1) : tot_ext;
    assign tot_pos  = !tot_reg[TOTAL_W-1] && (tot_reg != '0);
    assign dividend = tot_mag + MAG_W'(cnt_reg >> 1);

    sra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // memories
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            name_buf[name_len_reg[NB_IDX_W-1:0]] <= b;
        end
        buf_rd_reg <= name_buf[idx_reg[NB_IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (names_we) begin
            names_mem[name_addr] <= buf_rd_reg;
        end
        names_rd_reg <= names_mem[name_addr];
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[srch_slot] <= name_len_reg;
        end
        len_rd_reg <= len_mem[srch_slot];
    end

    always_ff @(posedge aclk) begin
        if (fig_we) begin
            fig_mem[slot_next] <= fig_wdata;
        end
        fig_rd_reg <= fig_mem[slot_reg];
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        name_len_next = name_len_reg;
        too_long_next = too_long_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        used_next     = used_reg;
        m_valid_next  = m_valid_reg;
        srch_next     = srch_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        oslot_next    = oslot_reg;
        status_next   = status_reg;
        fig_ok_next   = fig_ok_reg;
        v_next        = v_reg;
        cnt_next      = cnt_reg;
        tot_next      = tot_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        mean_next     = mean_reg;
        mneg_next     = mneg_reg;
        m_data_next   = m_data_reg;
        buf_we        = 1'b0;
        names_we      = 1'b0;
        len_we        = 1'b0;
        fig_we        = 1'b0;
        fig_wdata     = fig_rd_reg;
        div_start     = 1'b0;
        sum_ext       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accepted) begin
                    if (s_data.kind) begin
                        oslot_next = s_data.query_slot;
                        slot_next  = SLOT_W'(s_data.query_slot);
                        if (USED_W'(s_data.query_slot) < used_reg) begin
                            status_next = ST_QUERY_OK;
                            state_next  = S_FIG_RD;
                        end else begin
                            status_next = ST_EMPTY;
                            fig_ok_next = 1'b0;
                            state_next  = S_EMIT;
                        end
                    end else if (phase_reg == PH_NAME) begin
                        if (b == CH_SEMI) begin
                            phase_next = PH_START;
                        end else if (name_len_reg < LEN_W'(NAME_BYTES)) begin
                            buf_we        = 1'b1;
                            name_len_next = name_len_reg + 1'b1;
                        end else begin
                            too_long_next = 1'b1;
                        end
                    end else if (phase_reg == PH_START && b == CH_MINUS) begin
                        phase_next = PH_DIGIT;
                        neg_next   = 1'b1;
                    end else begin
                        phase_next = PH_DIGIT;
                        if (b == CH_NEWLINE) begin
                            v_next = neg_reg ? -acc_reg : acc_reg;
                            if (too_long_reg) begin
                                status_next = ST_TOO_LONG;
                                oslot_next  = '0;
                                fig_ok_next = 1'b0;
                                state_next  = S_EMIT;
                            end else begin
                                srch_next  = '0;
                                state_next = S_LEN_RD;
                            end
                        end else if (b != CH_DOT) begin
                            acc_next = acc_reg * RADIX + VALUE_W'(b) - VALUE_W'(CH_ZERO);
                        end
                    end
                end
            end

            S_LEN_RD: begin
                idx_next = '0;
                if (srch_reg == used_reg) begin
                    if (used_reg < USED_W'(STATIONS)) begin
                        state_next = S_COPY_RD;
                    end else begin
                        status_next = ST_FULL;
                        oslot_next  = '0;
                        fig_ok_next = 1'b0;
                        state_next  = S_EMIT;
                    end
                end else begin
                    state_next = S_LEN_CHK;
                end
            end

            S_LEN_CHK: begin
                if (len_rd_reg == name_len_reg) begin
                    if (name_len_reg == '0) begin
                        slot_next   = srch_slot;
                        status_next = ST_UPDATED;
                        state_next  = S_FIG_RD;
                    end else begin
                        state_next = S_BYTE_RD;
                    end
                end else begin
                    srch_next  = srch_reg + 1'b1;
                    state_next = S_LEN_RD;
                end
            end

            S_BYTE_RD: begin
                state_next = S_BYTE_CHK;
            end

            S_BYTE_CHK: begin
                if (buf_rd_reg == names_rd_reg) begin
                    if (idx_reg + 1'b1 == name_len_reg) begin
                        slot_next   = srch_slot;
                        status_next = ST_UPDATED;
                        state_next  = S_FIG_RD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_BYTE_RD;
                    end
                end else begin
                    srch_next  = srch_reg + 1'b1;
                    state_next = S_LEN_RD;
                end
            end

            S_FIG_RD: begin
                state_next = S_FIG_UPD;
            end

            S_FIG_UPD: begin
                oslot_next  = OUT_SLOT_W'(slot_reg);
                fig_ok_next = 1'b1;
                state_next  = S_DIV_START;
                if (status_reg == ST_QUERY_OK) begin
                    cnt_next = fig_rd_reg.count;
                    tot_next = fig_rd_reg.total;
                    min_next = fig_rd_reg.minimum;
                    max_next = fig_rd_reg.maximum;
                end else begin
                    min_next = fig_rd_reg.minimum;
                    max_next = fig_rd_reg.maximum;
                    if (v_reg < fig_rd_reg.minimum) begin
                        min_next = v_reg;
                    end else if (v_reg > fig_rd_reg.maximum) begin
                        max_next = v_reg;
                    end
                    sum_ext = {fig_rd_reg.total[TOTAL_W-1], fig_rd_reg.total}
                              + {{(MAG_W-VALUE_W){v_reg[VALUE_W-1]}}, v_reg};
                    if (sum_ext[MAG_W-1] != sum_ext[MAG_W-2]) begin
                        tot_next = sum_ext[MAG_W-1] ? TOTAL_MIN : TOTAL_MAX;
                    end else begin
                        tot_next = sum_ext[TOTAL_W-1:0];
                    end
                    cnt_next = (fig_rd_reg.count == '1) ? fig_rd_reg.count
                                                        : fig_rd_reg.count + 1'b1;
                    fig_we            = 1'b1;
                    fig_wdata.count   = cnt_next;
                    fig_wdata.total   = tot_next;
                    fig_wdata.minimum = min_next;
                    fig_wdata.maximum = max_next;
                end
            end

            S_COPY_RD: begin
                if (idx_reg == name_len_reg) begin
                    // new station: length and first figures
                    slot_next         = srch_slot;
                    oslot_next        = OUT_SLOT_W'(srch_slot);
                    len_we            = 1'b1;
                    cnt_next          = COUNT_W'(1);
                    tot_next          = {{(TOTAL_W-VALUE_W){v_reg[VALUE_W-1]}}, v_reg};
                    min_next          = v_reg;
                    max_next          = v_reg;
                    fig_we            = 1'b1;
                    fig_wdata.count   = cnt_next;
                    fig_wdata.total   = tot_next;
                    fig_wdata.minimum = v_reg;
                    fig_wdata.maximum = v_reg;
                    used_next         = used_reg + 1'b1;
                    status_next       = ST_INSERTED;
                    fig_ok_next       = 1'b1;
                    state_next        = S_DIV_START;
                end else begin
                    state_next = S_COPY_WR;
                end
            end

            S_COPY_WR: begin
                names_we   = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = S_COPY_RD;
            end

            S_DIV_START: begin
                mneg_next = !tot_pos;
                if (cnt_reg == '0) begin
                    mean_next  = '0;
                    state_next = S_EMIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV_WAIT;
                end
            end

            S_DIV_WAIT: begin
                if (div_done) begin
                    if (!mneg_reg) begin
                        mean_next = (div_quo > MAG_W'(32767)) ? 16'sh7FFF
                                                             : div_quo[VALUE_W-1:0];
                    end else begin
                        mean_next = (div_quo > MAG_W'(32768)) ? 16'sh8000
                                                             : -div_quo[VALUE_W-1:0];
                    end
                    state_next = S_EMIT;
                end
            end

            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_data_next.status = status_reg;
                    m_data_next.slot   = oslot_reg;
                    if (fig_ok_reg) begin
                        m_data_next.count       = cnt_reg;
                        m_data_next.total       = tot_reg;
                        m_data_next.minimum     = min_reg;
                        m_data_next.maximum     = max_reg;
                        m_data_next.mean_tenths = mean_reg;
                    end else begin
                        m_data_next.count       = '0;
                        m_data_next.total       = '0;
                        m_data_next.minimum     = '0;
                        m_data_next.maximum     = '0;
                        m_data_next.mean_tenths = '0;
                    end
                    // a finished line restarts parsing; queries leave it alone
                    if (status_reg != ST_QUERY_OK && status_reg != ST_EMPTY) begin
                        phase_next    = PH_NAME;
                        name_len_next = '0;
                        too_long_next = 1'b0;
                        neg_next      = 1'b0;
                        acc_next      = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_NAME;
            name_len_reg <= '0;
            too_long_reg <= 1'b0;
            neg_reg      <= 1'b0;
            acc_reg      <= '0;
            used_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            name_len_reg <= name_len_next;
            too_long_reg <= too_long_next;
            neg_reg      <= neg_next;
            acc_reg      <= acc_next;
            used_reg     <= used_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        srch_reg   <= srch_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        oslot_reg  <= oslot_next;
        status_reg <= status_next;
        fig_ok_reg <= fig_ok_next;
        v_reg      <= v_next;
        cnt_reg    <= cnt_next;
        tot_reg    <= tot_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        mean_reg   <= mean_next;
        mneg_reg   <= mneg_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for station_record_aggregator: random and directed line/query traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sra_pkg::*;

    // Station table model: mirrors the line parser and per-slot statistics.
    class station_table;
        logic [1:0]  phase;
        byte unsigned name_buf[$];
        bit          too_long;
        bit          neg;
        logic [15:0] accum;
        int unsigned used;
        byte unsigned names[int][$];
        logic [31:0] cnt[int];
        longint      tot[int];
        int          mn[int];
        int          mx[int];
        sra_out_t    expected_words[$];
        int          errors;

        function new();
            phase = 0; too_long = 0; neg = 0; accum = 0; used = 0; errors = 0;
        endfunction

        function logic signed [15:0] rounded_mean(int s);
            longint sum, c, m;
            sum = tot[s];
            c = cnt[s];
            if (c == 0) return 0;
            if (sum > 0) sum += c / 2;
            else sum -= c / 2;
            m = sum / c;
            if (m > 32767) m = 32767;
            if (m < -32768) m = -32768;
            return m[15:0];
        endfunction

        function sra_out_t figures(logic [2:0] st, int s, bit show);
            sra_out_t w;
            w = '0;
            w.status = st;
            w.slot = s[9:0];
            if (show) begin
                w.count = cnt[s];
                w.total = tot[s][47:0];
                w.minimum = mn[s][15:0];
                w.maximum = mx[s][15:0];
                w.mean_tenths = rounded_mean(s);
            end
            return w;
        endfunction

        function void end_of_line();
            logic [15:0] raw;
            int v, s;
            longint t;
            raw = neg ? 16'(0 - accum) : accum;
            v = $signed(raw);
            if (too_long) begin
                expected_words.push_back(figures(ST_TOO_LONG, 0, 0));
            end else begin
                for (s = 0; s < used; s++)
                    if (names[s] == name_buf) break;
                if (s < used) begin
                    if (v < mn[s]) mn[s] = v;
                    else if (v > mx[s]) mx[s] = v;
                    t = tot[s] + v;
                    if (t > 64'sd140737488355327) t = 64'sd140737488355327;
                    if (t < -64'sd140737488355328) t = -64'sd140737488355328;
                    tot[s] = t;
                    if (cnt[s] != 32'hFFFF_FFFF) cnt[s]++;
                    expected_words.push_back(figures(ST_UPDATED, s, 1));
                end else if (used < STATIONS) begin
                    s = used++;
                    names[s] = name_buf;
                    cnt[s] = 1; tot[s] = v; mn[s] = v; mx[s] = v;
                    expected_words.push_back(figures(ST_INSERTED, s, 1));
                end else begin
                    expected_words.push_back(figures(ST_FULL, 0, 0));
                end
            end
            phase = 0; name_buf.delete(); too_long = 0; neg = 0; accum = 0;
        endfunction

        function void note_input(sra_in_t w);
            if (w.kind) begin
                if (w.query_slot < used)
                    expected_words.push_back(figures(ST_QUERY_OK, w.query_slot, 1));
                else
                    expected_words.push_back(figures(ST_EMPTY, w.query_slot, 0));
                return;
            end
            if (phase == 0) begin
                if (w.data_byte == CH_SEMI) phase = 1;
                else if (name_buf.size() < NAME_BYTES) name_buf.push_back(w.data_byte);
                else too_long = 1;
                return;
            end
            if (phase == 1) begin
                phase = 2;
                if (w.data_byte == CH_MINUS) begin
                    neg = 1;
                    return;
                end
            end
            if (w.data_byte == CH_NEWLINE) end_of_line();
            else if (w.data_byte != CH_DOT)
                accum = 16'(accum * 16'd10 + {8'd0, w.data_byte} - {8'd0, CH_ZERO});
        endfunction

        function void check_result(sra_out_t got);
            sra_out_t e;
            if (expected_words.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.slot !== e.slot) begin
                $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
            end
            if (got.count !== e.count) begin
                $error("count exp %0d got %0d", e.count, got.count); errors++;
            end
            if (got.total !== e.total) begin
                $error("total exp %0d got %0d", e.total, got.total); errors++;
            end
            if (got.minimum !== e.minimum) begin
                $error("minimum exp %0d got %0d", e.minimum, got.minimum); errors++;
            end
            if (got.maximum !== e.maximum) begin
                $error("maximum exp %0d got %0d", e.maximum, got.maximum); errors++;
            end
            if (got.mean_tenths !== e.mean_tenths) begin
                $error("mean_tenths exp %0d got %0d", e.mean_tenths, got.mean_tenths);
                errors++;
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sra_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    sra_out_t m_data;

    station_record_aggregator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    station_table table_model = new();
    int  send_idle_pct;     // chance per cycle the sender holds off
    int  recv_stall_pct;    // chance per cycle the receiver stalls
    int  idle_cycles;       // cycles with no word moved on either channel, for the watchdog
    int  words_sent;
    // Station names reused so lines hit known slots; the rest are fresh.
    byte unsigned pool[$][$];

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Sample both channels at the rising edge; this is where words move.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) table_model.note_input(s_data);
            if (m_valid && m_ready) table_model.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: ready decided per falling edge from the stall rate.
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: line ends cost a table scan over the stored slots plus
    // the divider, stretched by receiver stalls.
    always @(posedge aclk) begin
        if (idle_cycles > 40000) begin
            $display("[station_record_aggregator] ERROR");
            $finish;
        end
    end

    // Present one word and hold it until it is taken. Valid stays up on return;
    // the next word replaces it, or wait_drained takes it down.
    task automatic send_word(sra_in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(byte unsigned b);
        sra_in_t w;
        w = '0;
        w.data_byte = b;
        w.query_slot = 10'($urandom);  // ignored bits still toggle
        send_word(w);
    endtask

    task automatic send_query(int q);
        sra_in_t w;
        w.kind = 1;
        w.data_byte = 8'($urandom);
        w.query_slot = q[9:0];
        send_word(w);
    endtask

    // Queries mostly slots that were written; otherwise any slot, used or not.
    function automatic int pick_query();
        if (table_model.used > 0 && $urandom_range(3) != 0)
            return $urandom_range(table_model.used - 1);
        return $urandom_range(1023);
    endfunction

    task automatic send_line(byte unsigned nm[$], string value);
        foreach (nm[i]) send_byte(nm[i]);
        send_byte(CH_SEMI);
        for (int i = 0; i < value.len(); i++) send_byte(value[i]);
        send_byte(CH_NEWLINE);
    endtask

    function automatic string rand_value();
        string v;
        int d;
        v = ($urandom_range(1)) ? "-" : "";
        d = $urandom_range(2, 1);
        repeat (d) v = {v, string'(8'("0" + $urandom_range(9)))};
        v = {v, ".", string'(8'("0" + $urandom_range(9)))};
        return v;
    endfunction

    function automatic void make_name(output byte unsigned nm[$], input int len);
        nm.delete();
        repeat (len) begin
            byte unsigned c;
            do c = 8'($urandom); while (c == CH_SEMI);
            nm.push_back(c);
        end
    endfunction

    task automatic wait_drained();
        s_valid <= 0;
        @(negedge aclk);
        while (table_model.expected_words.size() != 0) @(negedge aclk);
    endtask

    task automatic random_phase(int n, int sidle, int rstall);
        byte unsigned nm[$];
        int r, target;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        target = words_sent + n;
        while (words_sent < target) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_query(pick_query());
            end else if (r < 80) begin
                if (pool.size() > 0 && $urandom_range(2) != 0)
                    nm = pool[$urandom_range(pool.size() - 1)];
                else begin
                    make_name(nm, $urandom_range(6, 1));
                    pool.push_back(nm);
                end
                send_line(nm, rand_value());
            end else if (r < 92) begin
                // odd value text: stray bytes other than a dot, a newline or a leading minus are taken as digits
                make_name(nm, $urandom_range(3, 1));
                send_line(nm, {string'(8'($urandom_range(255))),
                               string'(8'($urandom_range(255)))});
            end else begin
                // raw noise; newline in a name is just a name byte
                repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        byte unsigned nm[$];
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        idle_cycles = 0;
        words_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: first insert, update, extremes, empty-value forms, queries.
        nm = '{8'h41};
        send_line(nm, "12.3");
        send_line(nm, "-99.9");
        send_line(nm, "3276.7");
        send_line(nm, "");
        send_line(nm, "-");
        send_query(0);
        send_query(1023);
        nm = '{8'h0A, 8'hFF, 8'h00};
        send_line(nm, "9-9");
        make_name(nm, NAME_BYTES);
        send_line(nm, "1.0");
        make_name(nm, NAME_BYTES + 3);
        send_line(nm, "2.0");
        send_query(1);
        send_query(2);
        wait_drained();

        random_phase(350, 0, 0);
        random_phase(250, 85, 0);
        // hold off until the table has answered everything
        wait_drained();
        random_phase(250, 0, 85);
        random_phase(250, 11, 11);
        random_phase(40, 0, 0);

        // Closing line and queries at both ends of the table.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        nm = '{8'h7E, 8'h7E, 8'h7E, 8'h7E};
        send_line(nm, "5");
        send_query(1023);
        send_query(0);

        wait_drained();
        repeat (200) @(posedge aclk);
        if (table_model.errors == 0 && table_model.expected_words.size() == 0)
            $display("[station_record_aggregator] OK");
        else
            $display("[station_record_aggregator] ERROR");
        $finish;
    end
endmodule

/* sim.f */
design/sra_pkg.sv
design/sra_div.sv
design/station_record_aggregator.sv
tb/tb_top.sv
